// ===== hw/rtl/vec3_arithmetic_unit_macros.svh =====
// Assertion macros for the vector ALU
`ifndef VEC3_ARITHMETIC_UNIT_MACROS_SVH
`define VEC3_ARITHMETIC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vau assertion failed");
`define VAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vau assertion failed");
`else
`define VAU_ASSERT_IMP(lbl, ante, cons)
`define VAU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/vau_pkg.sv =====
// Types, codes and helpers shared by the vector ALU
`default_nettype none
package vau_pkg;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SQRT_STAGES = 32;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_NEG       = 4'd2,
    OP_SCALE     = 4'd3,
    OP_DIV       = 4'd4,
    OP_DOT       = 4'd5,
    OP_CROSS     = 4'd6,
    OP_NORM2     = 4'd7,
    OP_NORM      = 4'd8,
    OP_NORMALIZE = 4'd9,
    OP_TRUNC     = 4'd10,
    OP_CLAMP     = 4'd11
  } op_e;

  typedef enum logic [0:0] {
    CFG_CLAMP_LOW  = 1'b0,
    CFG_CLAMP_HIGH = 1'b1
  } cfg_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  typedef struct packed {
    logic [31:0] vec;
    logic        sat;
    logic [63:0] p0;
    logic [31:0] aabs;
    logic        aneg;
  } lane_out_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [2:0][31:0] vec;
    logic [31:0]      scalar;
    logic             sat;
    logic [63:0]      ss;
    logic [2:0][31:0] aabs;
    logic [2:0]       aneg;
    logic [31:0]      sabs;
    logic             sneg;
    logic             dz;
  } mid_t;

  typedef struct packed {
    mid_t        mid;
    logic [31:0] root;
  } post_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > 66'sd2147483647) begin
      r.val = S32_MAX;
      r.sat = 1'b1;
    end else if (v < -66'sd2147483648) begin
      r.val = S32_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/vau_in_if.sv =====
// Request channel carrying one vector operation
`default_nettype none
interface vau_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         op;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar_in;
  modport source (output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, input ready);
  modport sink (input valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vau_out_if.sv =====
// Response channel carrying one vector result
`default_nettype none
interface vau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic signed [31:0] res_scalar;
  logic [1:0]         status;
  modport source (output valid, res_x, res_y, res_z, res_scalar, status, input ready);
  modport sink (input valid, res_x, res_y, res_z, res_scalar, status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vau_lane.sv =====
// One component lane: products and per-component operations
`default_nettype none
module vau_lane #(
  parameter int unsigned FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] a0_i,
  input  logic signed [31:0] a1_i,
  input  logic signed [31:0] a2_i,
  input  logic signed [31:0] b0_i,
  input  logic signed [31:0] b1_i,
  input  logic signed [31:0] b2_i,
  input  logic signed [31:0] s_i,
  input  logic signed [31:0] lo_i,
  input  logic signed [31:0] hi_i,
  output vau_pkg::lane_out_t res_o
);
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
  localparam logic [31:0] FMASK = ONE - 32'd1;

  logic signed [31:0] x0, y0;
  logic signed [63:0] p0_d, p1_d;
  logic [3:0]         op_q;
  logic signed [31:0] a_q, b_q;
  logic signed [63:0] p0_q, p1_q;

  always_comb begin
    x0 = (op_i == vau_pkg::OP_CROSS) ? a1_i : a0_i;
    case (op_i)
      vau_pkg::OP_SCALE: y0 = s_i;
      vau_pkg::OP_CROSS: y0 = b2_i;
      vau_pkg::OP_DOT:   y0 = b0_i;
      default:           y0 = a0_i;
    endcase
    p0_d = x0 * y0;
    p1_d = a2_i * b1_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_i;
      a_q  <= a0_i;
      b_q  <= b0_i;
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
  end

  logic signed [32:0] sum_add, sum_sub, sum_neg;
  logic signed [63:0] scl;
  logic signed [64:0] dif, crs;
  logic [31:0]        trc;
  logic signed [31:0] clp_t, clp;
  vau_pkg::sat_t      r;

  always_comb begin
    sum_add = 33'(a_q) + 33'(b_q);
    sum_sub = 33'(a_q) - 33'(b_q);
    sum_neg = 33'sd0 - 33'(a_q);
    scl     = p0_q >>> FRAC_BITS;
    dif     = 65'(p0_q) - 65'(p1_q);
    crs     = dif >>> FRAC_BITS;
    trc     = (a_q & ~FMASK) + ((a_q[31] && ((a_q & FMASK) != '0)) ? ONE : 32'd0);
    clp_t   = (a_q < lo_i) ? lo_i : a_q;
    clp     = (clp_t > hi_i) ? hi_i : clp_t;
    case (op_q)
      vau_pkg::OP_ADD:   r = vau_pkg::sat32(66'(sum_add));
      vau_pkg::OP_SUB:   r = vau_pkg::sat32(66'(sum_sub));
      vau_pkg::OP_NEG:   r = vau_pkg::sat32(66'(sum_neg));
      vau_pkg::OP_SCALE: r = vau_pkg::sat32(66'(scl));
      vau_pkg::OP_CROSS: r = vau_pkg::sat32(66'(crs));
      vau_pkg::OP_TRUNC: r = '{val: trc, sat: 1'b0};
      vau_pkg::OP_CLAMP: r = '{val: clp, sat: 1'b0};
      default:           r = '0;
    endcase
    res_o.vec  = r.val;
    res_o.sat  = r.sat;
    res_o.p0   = p0_q;
    res_o.aneg = a_q[31];
    res_o.aabs = a_q[31] ? (~a_q + 32'd1) : a_q;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/vau_merge.sv =====
// Merge stage: combine lane results, sums and flags
`default_nettype none
module vau_merge #(
  parameter int unsigned FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [3:0]                    op_i,
  input  logic signed [31:0]            s_i,
  input  vau_pkg::lane_out_t [2:0]      lane_i,
  output vau_pkg::mid_t                 mid_o
);
  logic signed [65:0] sum;
  logic signed [65:0] flr;
  vau_pkg::sat_t      scl;
  vau_pkg::mid_t      mid_d, mid_q;

  always_comb begin
    sum = 66'($signed(lane_i[0].p0)) + 66'($signed(lane_i[1].p0))
        + 66'($signed(lane_i[2].p0));
    flr = sum >>> FRAC_BITS;
    scl = vau_pkg::sat32(flr);
    mid_d.op = op_i;
    for (int i = 0; i < 3; i++) begin
      mid_d.vec[i]  = lane_i[i].vec;
      mid_d.aabs[i] = lane_i[i].aabs;
      mid_d.aneg[i] = lane_i[i].aneg;
    end
    mid_d.ss = sum[63:0];
    case (op_i)
      vau_pkg::OP_DOT, vau_pkg::OP_NORM2: begin
        mid_d.scalar = scl.val;
        mid_d.sat    = scl.sat;
      end
      default: begin
        mid_d.scalar = '0;
        mid_d.sat    = lane_i[0].sat | lane_i[1].sat | lane_i[2].sat;
      end
    endcase
    mid_d.sneg = s_i[31];
    mid_d.sabs = s_i[31] ? (~s_i + 32'd1) : s_i;
    mid_d.dz   = (op_i == vau_pkg::OP_DIV) ? (s_i == '0) : (sum[63:0] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;
endmodule
`default_nettype wire

// ===== hw/rtl/vau_sqrt.sv =====
// Pipelined integer square root, two radicand bits per stage
`default_nettype none
module vau_sqrt (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [63:0]   x_i,
  input  vau_pkg::mid_t mid_i,
  output logic [31:0]   root_o,
  output vau_pkg::mid_t mid_o
);
  localparam int unsigned NS = vau_pkg::SQRT_STAGES;

  logic [33:0]   rem_q  [NS];
  logic [31:0]   root_q [NS];
  logic [63:0]   x_q    [NS];
  vau_pkg::mid_t mid_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [33:0]   rem_p;
    logic [31:0]   root_p;
    logic [63:0]   x_p;
    vau_pkg::mid_t mid_p;
    logic [35:0]   rem_sh, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x_i;
      assign mid_p  = mid_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign x_p    = x_q[k-1];
      assign mid_p  = mid_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_p, x_p[63:62]};
      trial  = {2'b00, root_p, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        root_q[k] <= {root_p[30:0], ge};
        x_q[k]    <= {x_p[61:0], 2'b00};
        mid_q[k]  <= mid_p;
      end
    end
  end

  assign root_o = root_q[NS-1];
  assign mid_o  = mid_q[NS-1];
endmodule
`default_nettype wire

// ===== hw/rtl/vau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module vau_div #(
  parameter int unsigned FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [32+FRAC_BITS-1:0] dvd_i,
  input  logic [31:0]            dsr_i,
  output logic [32+FRAC_BITS-1:0] quo_o
);
  localparam int unsigned DW = 32 + FRAC_BITS;

  logic [31:0]   rem_q [DW];
  logic [DW-1:0] nq_q  [DW];
  logic [31:0]   dsr_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [31:0]   rem_p;
    logic [DW-1:0] nq_p;
    logic [31:0]   dsr_p;
    logic [32:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign nq_p  = dvd_i;
      assign dsr_p = dsr_i;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign nq_p  = nq_q[k-1];
      assign dsr_p = dsr_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_p, nq_p[DW-1]};
      ge     = rem_sh >= {1'b0, dsr_p};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? 32'(rem_sh - {1'b0, dsr_p}) : rem_sh[31:0];
        nq_q[k]  <= {nq_p[DW-2:0], ge};
        dsr_q[k] <= dsr_p;
      end
    end
  end

  assign quo_o = nq_q[DW-1];
endmodule
`default_nettype wire

// ===== hw/rtl/vec3_arithmetic_unit.sv =====
// Three-component Q-format vector ALU. One transaction is accepted every cycle unless the
// pipe is held by a waiting result, as described below. Every transaction passes through
// the 32-stage square-root pipeline and the (32 + FRAC_BITS)-stage restoring divider.
// Three lanes form the per-component products and results, a merge stage sums them,
// and an output register parts the response side. While a result waits, the pipe keeps
// advancing until a transaction reaches its last stage; from then on the whole pipe and
// the request side hold until the result is taken. Clamp bounds are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while idle, as the
// block itself does not enforce this.
`default_nettype none
`include "vec3_arithmetic_unit_macros.svh"
module vec3_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  vau_in_if.sink      req_i,
  vau_out_if.source   rsp_o
);
  localparam int unsigned DIV_W = 32 + FRAC_BITS;
  localparam int unsigned NST = 3 + vau_pkg::SQRT_STAGES + DIV_W;

  logic signed [31:0] clamp_lo_q, clamp_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_lo_q <= 32'sd0;
      clamp_hi_q <= 32'sd65535;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vau_pkg::CFG_CLAMP_LOW:  clamp_lo_q <= cfg_data_i;
        vau_pkg::CFG_CLAMP_HIGH: clamp_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic           en, out_en;
  logic [NST-1:0] vld_q;
  logic           out_vld_q;

  assign out_en      = !out_vld_q || rsp_o.ready;
  assign en          = out_en || !vld_q[NST-1];
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], req_i.valid};
    end
  end

  logic [3:0]               op1_q, op2_q;
  logic signed [31:0]       a1_q [3];
  logic signed [31:0]       b1_q [3];
  logic signed [31:0]       s1_q, s2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q   <= req_i.op;
      a1_q[0] <= req_i.a_x;
      a1_q[1] <= req_i.a_y;
      a1_q[2] <= req_i.a_z;
      b1_q[0] <= req_i.b_x;
      b1_q[1] <= req_i.b_y;
      b1_q[2] <= req_i.b_z;
      s1_q    <= req_i.scalar_in;
      op2_q   <= op1_q;
      s2_q    <= s1_q;
    end
  end

  vau_pkg::lane_out_t [2:0] lane;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .op_i  (op1_q),
      .a0_i  (a1_q[i]),
      .a1_i  (a1_q[(i+1)%3]),
      .a2_i  (a1_q[(i+2)%3]),
      .b0_i  (b1_q[i]),
      .b1_i  (b1_q[(i+1)%3]),
      .b2_i  (b1_q[(i+2)%3]),
      .s_i   (s1_q),
      .lo_i  (clamp_lo_q),
      .hi_i  (clamp_hi_q),
      .res_o (lane[i])
    );
  end

  vau_pkg::mid_t mid, mid_sq;
  logic [31:0]   root;

  vau_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .op_i   (op2_q),
    .s_i    (s2_q),
    .lane_i (lane),
    .mid_o  (mid)
  );

  vau_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (mid.ss),
    .mid_i  (mid),
    .root_o (root),
    .mid_o  (mid_sq)
  );

  logic [31:0]             dsr;
  logic [2:0][DIV_W-1:0]   quo;
  vau_pkg::post_t          post_q [DIV_W];

  assign dsr = (mid_sq.op == vau_pkg::OP_DIV) ? mid_sq.sabs : root;

  for (genvar i = 0; i < 3; i++) begin : g_div
    vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .dvd_i ({mid_sq.aabs[i], {FRAC_BITS{1'b0}}}),
      .dsr_i (dsr),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      post_q[0] <= '{mid: mid_sq, root: root};
      for (int k = 1; k < DIV_W; k++) begin
        post_q[k] <= post_q[k-1];
      end
    end
  end

  vau_pkg::mid_t      pm;
  logic [31:0]        pr;
  logic [2:0][31:0]   dvec;
  logic [2:0]         dover;
  logic               neg;
  logic               big;
  logic [31:0]        x_d, y_d, z_d, sc_d;
  logic [1:0]         st_d;
  logic [31:0]        out_x_q, out_y_q, out_z_q, out_sc_q;
  logic [1:0]         out_st_q;

  always_comb begin
    pm = post_q[DIV_W-1].mid;
    pr = post_q[DIV_W-1].root;
    for (int i = 0; i < 3; i++) begin
      neg = pm.aneg[i] ^ ((pm.op == vau_pkg::OP_DIV) && pm.sneg);
      big = |quo[i][DIV_W-1:32];
      if (neg) begin
        dover[i] = big || (quo[i][31:0] > vau_pkg::S32_MIN);
        dvec[i]  = dover[i] ? vau_pkg::S32_MIN : (~quo[i][31:0] + 32'd1);
      end else begin
        dover[i] = big || quo[i][31];
        dvec[i]  = dover[i] ? vau_pkg::S32_MAX : quo[i][31:0];
      end
    end
    case (pm.op)
      vau_pkg::OP_DIV, vau_pkg::OP_NORMALIZE: begin
        sc_d = '0;
        if (pm.dz) begin
          x_d  = '0;
          y_d  = '0;
          z_d  = '0;
          st_d = vau_pkg::ST_DIVZ;
        end else begin
          x_d  = dvec[0];
          y_d  = dvec[1];
          z_d  = dvec[2];
          st_d = (|dover) ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
        end
      end
      vau_pkg::OP_NORM: begin
        x_d  = '0;
        y_d  = '0;
        z_d  = '0;
        sc_d = pr[31] ? vau_pkg::S32_MAX : pr;
        st_d = pr[31] ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
      end
      default: begin
        x_d  = pm.vec[0];
        y_d  = pm.vec[1];
        z_d  = pm.vec[2];
        sc_d = pm.scalar;
        st_d = pm.sat ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_x_q  <= x_d;
      out_y_q  <= y_d;
      out_z_q  <= z_d;
      out_sc_q <= sc_d;
      out_st_q <= st_d;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.res_x      = out_x_q;
  assign rsp_o.res_y      = out_y_q;
  assign rsp_o.res_z      = out_z_q;
  assign rsp_o.res_scalar = out_sc_q;
  assign rsp_o.status     = out_st_q;

  `VAU_ASSERT_NEXT(a_accept_enters, req_i.valid && req_i.ready, vld_q[0])
  `VAU_ASSERT_NEXT(a_stall_holds, out_vld_q && !rsp_o.ready && vld_q[NST-1], $stable(vld_q))
  `VAU_ASSERT_IMP(a_divz_zero, out_vld_q && out_st_q == vau_pkg::ST_DIVZ, out_x_q == '0 && out_y_q == '0 && out_z_q == '0 && out_sc_q == '0)
endmodule
`default_nettype wire

// ===== tb/vec3_arithmetic_unit_test.sv =====
// Self-checking testbench for the vector ALU: random and directed operations against a predictor
`timescale 1ns / 1ps
module vec3_arithmetic_unit_test;

  localparam int FRAC = 16;
  localparam logic signed [127:0] ONE_Q = 128'sd1 <<< FRAC;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]       op;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      s;
  } vec_req_t;

  typedef struct packed {
    logic [2:0][31:0] v;
    logic [31:0]      sc;
    logic [1:0]       st;
  } vec_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  vau_in_if req ();
  vau_out_if rsp ();

  vec3_arithmetic_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req),
    .rsp_o     (rsp)
  );

  vec_req_t pending_ops[$];
  vec_rsp_t expected_rsps[$];
  logic signed [31:0] bound_low;
  logic signed [31:0] bound_high;
  int mismatches;
  int send_gap;
  int rsp_stall;
  bit burst_mode;

  function automatic logic [31:0] limit32(input logic signed [127:0] v, inout bit f);
    if (v > $signed({96'd0, Q_MAX})) begin
      f = 1'b1;
      return Q_MAX;
    end
    if (v < -(128'sd1 <<< 31)) begin
      f = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic vec_rsp_t alu_predict(input vec_req_t r);
    vec_rsp_t o;
    logic signed [127:0] av[3];
    logic signed [127:0] bv[3];
    logic signed [127:0] sv;
    logic signed [127:0] nrm;
    logic signed [127:0] t;
    logic [127:0] sumsq;
    bit sat;
    bit dz;
    sat = 0;
    dz = 0;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      av[i] = $signed(r.a[i]);
      bv[i] = $signed(r.b[i]);
    end
    sv = $signed(r.s);
    sumsq = av[0] * av[0] + av[1] * av[1] + av[2] * av[2];
    case (r.op)
      vau_pkg::OP_ADD:
        for (int i = 0; i < 3; i++) o.v[i] = limit32(av[i] + bv[i], sat);
      vau_pkg::OP_SUB:
        for (int i = 0; i < 3; i++) o.v[i] = limit32(av[i] - bv[i], sat);
      vau_pkg::OP_NEG:
        for (int i = 0; i < 3; i++) o.v[i] = limit32(-av[i], sat);
      vau_pkg::OP_SCALE:
        for (int i = 0; i < 3; i++) o.v[i] = limit32((av[i] * sv) >>> FRAC, sat);
      vau_pkg::OP_DIV: begin
        if (sv == 0) dz = 1;
        else for (int i = 0; i < 3; i++) o.v[i] = limit32((av[i] <<< FRAC) / sv, sat);
      end
      vau_pkg::OP_DOT:
        o.sc = limit32((av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2]) >>> FRAC, sat);
      vau_pkg::OP_CROSS: begin
        o.v[0] = limit32((av[1] * bv[2] - av[2] * bv[1]) >>> FRAC, sat);
        o.v[1] = limit32((av[2] * bv[0] - av[0] * bv[2]) >>> FRAC, sat);
        o.v[2] = limit32((av[0] * bv[1] - av[1] * bv[0]) >>> FRAC, sat);
      end
      vau_pkg::OP_NORM2: o.sc = limit32($signed(sumsq) >>> FRAC, sat);
      vau_pkg::OP_NORM: o.sc = limit32($signed({64'd0, root_floor(sumsq[63:0])}), sat);
      vau_pkg::OP_NORMALIZE: begin
        nrm = $signed({64'd0, root_floor(sumsq[63:0])});
        if (nrm == 0) dz = 1;
        else for (int i = 0; i < 3; i++) o.v[i] = limit32((av[i] <<< FRAC) / nrm, sat);
      end
      vau_pkg::OP_TRUNC:
        for (int i = 0; i < 3; i++) o.v[i] = limit32(av[i] - av[i] % ONE_Q, sat);
      vau_pkg::OP_CLAMP: begin
        for (int i = 0; i < 3; i++) begin
          t = (av[i] < bound_low) ? bound_low : av[i];
          o.v[i] = (t > bound_high) ? bound_high : t[31:0];
        end
      end
      default: o = '0;
    endcase
    if (dz) o = '{v: '0, sc: '0, st: vau_pkg::ST_DIVZ};
    else o.st = sat ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
    return o;
  endfunction

  function automatic logic [31:0] draw_q();
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 6))
          0: return 32'd0;
          1: return 32'd1;
          2: return 32'hFFFF_FFFF;
          3: return Q_MAX;
          4: return Q_MIN;
          5: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      2: return $urandom();
      3: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      default: return ($urandom_range(0, 255) - 128) << FRAC;
    endcase
  endfunction

  function automatic vec_req_t draw_op();
    vec_req_t r;
    r.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
    for (int i = 0; i < 3; i++) begin
      r.a[i] = draw_q();
      r.b[i] = draw_q();
    end
    r.s = draw_q();
    if (r.op == vau_pkg::OP_DIV && $urandom_range(0, 7) == 0) r.s = '0;
    if (r.op == vau_pkg::OP_NORMALIZE && $urandom_range(0, 7) == 0) r.a = '0;
    return r;
  endfunction

  function automatic vec_req_t mk(input logic [3:0] op, input logic [31:0] a0, input logic [31:0] a1,
                                  input logic [31:0] a2, input logic [31:0] b0,
                                  input logic [31:0] b1, input logic [31:0] b2,
                                  input logic [31:0] s);
    vec_req_t r;
    r.op = op;
    r.a = {a2, a1, a0};
    r.b = {b2, b1, b0};
    r.s = s;
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() != 0 || req.valid || expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input vau_pkg::cfg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == vau_pkg::CFG_CLAMP_LOW) bound_low = val;
    else bound_high = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(alu_predict({req.op, req.a_z, req.a_y, req.a_x,
                                             req.b_z, req.b_y, req.b_x, req.scalar_in}));
      end
      if (!req.valid || req.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          vec_req_t nx;
          nx = pending_ops.pop_front();
          req.op <= nx.op;
          req.a_x <= nx.a[0];
          req.a_y <= nx.a[1];
          req.a_z <= nx.a[2];
          req.b_x <= nx.b[0];
          req.b_y <= nx.b[1];
          req.b_z <= nx.b[2];
          req.scalar_in <= nx.s;
          req.valid <= 1'b1;
          send_gap <= burst_mode ? 0 : $urandom_range(0, 6);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transaction");
          mismatches++;
        end else begin
          vec_rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp.res_x !== e.v[0]) begin
            $error("res_x expected %h got %h", e.v[0], rsp.res_x);
            mismatches++;
          end
          if (rsp.res_y !== e.v[1]) begin
            $error("res_y expected %h got %h", e.v[1], rsp.res_y);
            mismatches++;
          end
          if (rsp.res_z !== e.v[2]) begin
            $error("res_z expected %h got %h", e.v[2], rsp.res_z);
            mismatches++;
          end
          if (rsp.res_scalar !== e.sc) begin
            $error("res_scalar expected %h got %h", e.sc, rsp.res_scalar);
            mismatches++;
          end
          if (rsp.status !== e.st) begin
            $error("status expected %0d got %0d", e.st, rsp.status);
            mismatches++;
          end
        end
        rsp_stall = burst_mode ? 0 : $urandom_range(0, 6);
      end else if (rsp_stall > 0) begin
        rsp_stall--;
      end
      rsp.ready <= (rsp_stall == 0);
    end
  end

  initial begin
    logic [31:0] lows[4];
    logic [31:0] highs[4];
    mismatches = 0;
    burst_mode = 0;
    bound_low = 32'd0;
    bound_high = 32'd65535;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = vau_pkg::CFG_CLAMP_LOW;
    cfg_data_i = '0;
    req.valid = 1'b0;
    req.op = '0;
    req.a_x = '0;
    req.a_y = '0;
    req.a_z = '0;
    req.b_x = '0;
    req.b_y = '0;
    req.b_z = '0;
    req.scalar_in = '0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_ops.push_back(mk(vau_pkg::OP_ADD, Q_MAX, Q_MIN, 32'h0001_8000,
                             Q_MAX, Q_MIN, 32'hFFFF_0000, 0));
    pending_ops.push_back(mk(vau_pkg::OP_SUB, Q_MIN, Q_MAX, 32'd5, Q_MAX, Q_MIN, 32'd7, 0));
    pending_ops.push_back(mk(vau_pkg::OP_NEG, Q_MIN, Q_MAX, 32'hFFFF_FFFF, 0, 0, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_SCALE, Q_MAX, Q_MIN, 32'hFFFF_FFFF, 0, 0, 0, Q_MAX));
    pending_ops.push_back(mk(vau_pkg::OP_SCALE, 32'hFFFF_8000, 32'h0003_0000, 32'd1,
                             0, 0, 0, 32'h0000_8000));
    pending_ops.push_back(mk(vau_pkg::OP_DIV, 32'h0001_0000, Q_MIN, 32'd3, 0, 0, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_DIV, Q_MIN, 32'hFFFF_FFFF, 32'h0007_0000,
                             0, 0, 0, 32'hFFFF_FFFF));
    pending_ops.push_back(mk(vau_pkg::OP_DIV, 32'hFFF9_0000, 32'd1, Q_MAX,
                             0, 0, 0, 32'h0003_0000));
    pending_ops.push_back(mk(vau_pkg::OP_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0));
    pending_ops.push_back(mk(vau_pkg::OP_DOT, 32'h0002_0000, 32'hFFFF_FFFF, 32'd3,
                             32'h0000_8000, 32'd1, 32'hFFFF_0000, 0));
    pending_ops.push_back(mk(vau_pkg::OP_CROSS, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0));
    pending_ops.push_back(mk(vau_pkg::OP_CROSS, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_NORM2, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_NORM2, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_NORM, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_NORM, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_NORMALIZE, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    pending_ops.push_back(mk(vau_pkg::OP_NORMALIZE, 32'd1, 0, 0, 0, 0, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_NORMALIZE, 32'h0003_0000, 32'hFFFC_0000, Q_MIN,
                             0, 0, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_TRUNC, 32'hFFFE_8000, 32'h0001_FFFF, Q_MIN,
                             0, 0, 0, 0));
    pending_ops.push_back(mk(vau_pkg::OP_CLAMP, 32'hFFFF_FFFF, 32'h0000_8000, Q_MAX,
                             0, 0, 0, 0));
    pending_ops.push_back(mk(4'd12, Q_MAX, Q_MIN, 32'd1, Q_MAX, Q_MIN, 32'd1, Q_MAX));
    pending_ops.push_back(mk(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    for (int k = 0; k < 80; k++) pending_ops.push_back(draw_op());
    wait_idle();

    lows = '{32'hFFFF_0000, Q_MIN, Q_MAX, 32'h0000_0000};
    highs = '{32'h0001_0000, Q_MAX, Q_MIN, 32'h0000_0000};
    for (int p = 0; p < 5; p++) begin
      if (p < 4) begin
        write_reg(vau_pkg::CFG_CLAMP_LOW, lows[p]);
        write_reg(vau_pkg::CFG_CLAMP_HIGH, highs[p]);
      end else begin
        write_reg(vau_pkg::CFG_CLAMP_HIGH, $urandom());
        write_reg(vau_pkg::CFG_CLAMP_LOW, $urandom());
      end
      burst_mode = (p == 1 || p == 3);
      for (int k = 0; k < 70; k++) pending_ops.push_back(draw_op());
      wait_idle();
    end

    repeat (120) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vau_pkg.sv
hw/rtl/vau_in_if.sv
hw/rtl/vau_out_if.sv
hw/rtl/vau_lane.sv
hw/rtl/vau_merge.sv
hw/rtl/vau_sqrt.sv
hw/rtl/vau_div.sv
hw/rtl/vec3_arithmetic_unit.sv
tb/vec3_arithmetic_unit_test.sv
